// ----- sv/tga_rle_decoder_top_macros.svh -----
// Assertion macros for the TGA run-length decoder core.
`ifndef TGA_RLE_DECODER_TOP_MACROS_SVH
`define TGA_RLE_DECODER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset
`define TRD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset
`define TRD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/trd_pkg.sv -----
// Shared types, constants and helpers for the TGA run-length decoder.
package trd_pkg;

   // Register map (word index)
   localparam logic REG_BYTES_PER_PIXEL = 1'b0;
   localparam logic REG_IMAGE_PIXELS    = 1'b1;

   localparam int unsigned PADDR_W = 3;

   // Run headers have the top bit set
   localparam int unsigned HDR_RUN_BIT = 7;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       begin_image;
   } req_type;

   typedef struct packed {
      logic [31:0] pixel_value;
      logic [7:0]  repeat_count;
      logic [31:0] first_index;
      logic        image_done;
      logic        overflow_error;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  bytes_per_pixel;
      logic [31:0] image_pixels;
   } cfg_type;

   // Effective pixel width: 0 acts as 1, 5..7 act as 4
   function automatic logic [2:0] eff_bpp(input logic [2:0] bpp);
      logic [2:0] r;
      r = bpp;
      if (bpp == 3'd0) begin
         r = 3'd1;
      end else if (bpp > 3'd4) begin
         r = 3'd4;
      end
      return r;
   endfunction

endpackage

// ----- sv/trd_csr.sv -----
// Configuration register bank behind an APB-style port.
module trd_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [trd_pkg::PADDR_W-1:0] paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready,
   output trd_pkg::cfg_type            cfg
);
   import trd_pkg::*;

   logic [2:0]  bpp_ff;
   logic [31:0] pixels_ff;
   logic        wr_en;
   logic        reg_sel;

   assign pready  = 1'b1;
   assign reg_sel = paddr[2];
   assign wr_en   = psel & penable & pwrite & pready;

   // Register writes on the access cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff    <= 3'd4;
         pixels_ff <= 32'd1;
      end else if (wr_en) begin
         unique case (reg_sel)
            REG_BYTES_PER_PIXEL: bpp_ff    <= pwdata[2:0];
            REG_IMAGE_PIXELS:    pixels_ff <= pwdata;
            default:             ;
         endcase
      end
   end

   // Read mux
   always_comb begin
      unique case (reg_sel)
         REG_BYTES_PER_PIXEL: prdata = {29'd0, bpp_ff};
         REG_IMAGE_PIXELS:    prdata = pixels_ff;
         default:             prdata = 32'd0;
      endcase
   end

   assign cfg.bytes_per_pixel = bpp_ff;
   assign cfg.image_pixels    = pixels_ff;

endmodule

// ----- sv/trd_core.sv -----
// Packet parser, pixel gather and span output with a skid word.
module trd_core (
   input  logic             clock,
   input  logic             reset,
   input  trd_pkg::cfg_type cfg,
   input  logic             req_valid,
   output logic             req_ready,
   input  trd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output trd_pkg::rsp_type rsp_data
);
   import trd_pkg::*;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_PIXEL  = 2'd1,
      PH_HALT   = 2'd2
   } phase_type;

   phase_type   phase_ff, phase_in, cur_phase;
   logic [7:0]  left_ff, left_in, cur_left;
   logic        run_ff, run_in, cur_run;
   logic [1:0]  pos_ff, pos_in, cur_pos;
   logic [31:0] gather_ff, gather_in, cur_gather;
   logic [31:0] written_ff, written_in, cur_written;

   logic        out_valid_ff, skid_valid_ff;
   rsp_type     out_ff, skid_ff;

   logic        accept, out_take;
   logic        res_valid;
   rsp_type     res;

   logic [7:0]  hdr_count;
   logic [32:0] hdr_total;
   logic [31:0] gather_new;
   logic [2:0]  bpp;
   logic        pixel_last;
   logic [7:0]  span;
   logic [31:0] written_new;

   assign req_ready = ~skid_valid_ff;
   assign accept    = req_valid & req_ready;
   assign out_take  = out_valid_ff & rsp_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // Per-word decode: begin_image clears state first
   always_comb begin
      cur_phase   = req_data.begin_image ? PH_HEADER : phase_ff;
      cur_left    = req_data.begin_image ? 8'd0      : left_ff;
      cur_run     = req_data.begin_image ? 1'b0      : run_ff;
      cur_pos     = req_data.begin_image ? 2'd0      : pos_ff;
      cur_gather  = req_data.begin_image ? 32'd0     : gather_ff;
      cur_written = req_data.begin_image ? 32'd0     : written_ff;

      // raw: b+1, run: b-127; both are low seven bits plus one
      hdr_count   = {1'b0, req_data.data_byte[6:0]} + 8'd1;
      hdr_total   = {1'b0, cur_written} + {25'd0, hdr_count};

      bpp         = eff_bpp(cfg.bytes_per_pixel);
      gather_new  = cur_gather | ({24'd0, req_data.data_byte} << {cur_pos, 3'b000});
      pixel_last  = ({1'b0, cur_pos} + 3'd1) >= bpp;
      span        = cur_run ? cur_left : 8'd1;
      written_new = cur_written + {24'd0, span};

      phase_in    = cur_phase;
      left_in     = cur_left;
      run_in      = cur_run;
      pos_in      = cur_pos;
      gather_in   = cur_gather;
      written_in  = cur_written;

      res_valid   = 1'b0;
      res         = '0;

      unique case (cur_phase)
         PH_HEADER: begin
            run_in = req_data.data_byte[HDR_RUN_BIT];
            if (hdr_total > {1'b0, cfg.image_pixels}) begin
               res_valid          = 1'b1;
               res.first_index    = cur_written;
               res.overflow_error = 1'b1;
               phase_in           = PH_HALT;
            end else begin
               left_in   = hdr_count;
               pos_in    = 2'd0;
               gather_in = 32'd0;
               phase_in  = PH_PIXEL;
            end
         end
         PH_PIXEL: begin
            if (!pixel_last) begin
               gather_in = gather_new;
               pos_in    = cur_pos + 2'd1;
            end else begin
               res_valid        = 1'b1;
               res.pixel_value  = gather_new;
               res.repeat_count = span;
               res.first_index  = cur_written;
               left_in          = cur_run ? 8'd0 : cur_left - 8'd1;
               written_in       = written_new;
               pos_in           = 2'd0;
               gather_in        = 32'd0;
               phase_in         = (left_in == 8'd0) ? PH_HEADER : PH_PIXEL;
               if (written_new >= cfg.image_pixels) begin
                  res.image_done = 1'b1;
                  phase_in       = PH_HALT;
               end
            end
         end
         default: ;
      endcase
   end

   // Decoder state plus output word and skid word
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEADER;
         left_ff       <= 8'd0;
         run_ff        <= 1'b0;
         pos_ff        <= 2'd0;
         gather_ff     <= 32'd0;
         written_ff    <= 32'd0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff   <= phase_in;
            left_ff    <= left_in;
            run_ff     <= run_in;
            pos_ff     <= pos_in;
            gather_ff  <= gather_in;
            written_ff <= written_in;
         end
         if (skid_valid_ff) begin
            if (out_take) begin
               out_ff        <= skid_ff;
               skid_valid_ff <= 1'b0;
            end
         end else if (accept && res_valid) begin
            if (!out_valid_ff || out_take) begin
               out_ff       <= res;
               out_valid_ff <= 1'b1;
            end else begin
               skid_ff       <= res;
               skid_valid_ff <= 1'b1;
            end
         end else if (out_take) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

`include "tga_rle_decoder_top_macros.svh"

   `TRD_ASSERT_NOW(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff, "skid word without output word")
   `TRD_ASSERT_NOW(a_overflow_empty, clock, reset, out_valid_ff && out_ff.overflow_error, out_ff.repeat_count == 8'd0 && out_ff.pixel_value == 32'd0 && !out_ff.image_done, "overflow word carries a span")
   `TRD_ASSERT_NOW(a_span_nonzero, clock, reset, out_valid_ff && !out_ff.overflow_error, out_ff.repeat_count != 8'd0, "empty span")
   `TRD_ASSERT_NOW(a_pixel_has_left, clock, reset, phase_ff == PH_PIXEL, left_ff != 8'd0, "pixel phase with no pixels left")
   `TRD_ASSERT_NEXT(a_stall_holds, clock, reset, out_valid_ff && !rsp_ready, out_valid_ff && $stable(out_ff), "output word changed under stall")

endmodule

// ----- sv/tga_rle_decoder_top.sv -----
// A byte that completes a pixel or overflows registers its span in the output or skid word.
// Throughput: one byte per cycle while req_ready is high; a skid word keeps input open while one span waits.
// Input stalls only when both the output word and the skid word hold spans.
// Reset (synchronous, high): decoder expects a header, counters clear,
// bytes_per_pixel resets to 4 and image_pixels to 1.
module tga_rle_decoder_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  trd_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output trd_pkg::rsp_type            rsp_data,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [trd_pkg::PADDR_W-1:0] paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);
   import trd_pkg::*;

   cfg_type cfg;

   // Register bank
   trd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Decoder datapath
   trd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
